// ----- rtl/multi_core_barrier_unit_core_defines.svh -----
// Assertion macros shared by the barrier unit checkers.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef MULTI_CORE_BARRIER_UNIT_CORE_DEFINES_SVH
`define MULTI_CORE_BARRIER_UNIT_CORE_DEFINES_SVH

// Property checked only while reset is released.
`define MCBU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define MCBU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mcbu_pkg.sv -----
// Shared types and constants for the barrier unit.
// Depends on nothing; used by every module of the block.
package mcbu_pkg;

	localparam int CORE_W      = 4;
	localparam int BAR_W       = 2;
	localparam int THR_W       = 5;
	localparam int BIU_W       = 3;
	localparam int CNT_W       = 3;
	localparam int WAKE_W      = 16;
	localparam int NUM_THR     = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 5;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	localparam logic [THR_W-1:0] THR_RESET = 5'd16;
	localparam logic [BIU_W-1:0] BIU_RESET = 3'd4;
	localparam logic [CNT_W-1:0] CNT_MAX   = 3'd7;

	localparam logic OP_WAIT  = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LAST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BARRIERS_IN_USE = 3'd4;

	typedef enum logic [1:0] {
		STATUS_PENDING = 2'd0,
		STATUS_GRANTED = 2'd1,
		STATUS_FOUND   = 2'd2,
		STATUS_NONE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_FULL  = 2'b10
	} ctrl_state_t;

	typedef struct packed {
		logic step_en;
	} ctrl_cmd_t;

endpackage

// ----- rtl/mcbu_ctrl.sv -----
// Controller of the barrier unit: output register occupancy and handshakes.
// Depends on mcbu_pkg.
module mcbu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output mcbu_pkg::ctrl_cmd_t cmd
);

	mcbu_pkg::ctrl_state_t state_q;
	mcbu_pkg::ctrl_state_t state_d;

	// A new request may enter when the result register is free or drains now.
	assign s_tready    = (state_q == mcbu_pkg::ST_EMPTY) || m_tready;
	assign m_tvalid    = (state_q == mcbu_pkg::ST_FULL);
	assign cmd.step_en = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mcbu_pkg::ST_EMPTY: begin
				if (s_tvalid) state_d = mcbu_pkg::ST_FULL;
			end
			mcbu_pkg::ST_FULL: begin
				if (m_tready && !s_tvalid) state_d = mcbu_pkg::ST_EMPTY;
			end
			default: state_d = mcbu_pkg::ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcbu_pkg::ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/mcbu_datapath.sv -----
// Datapath of the barrier unit: barrier state, pending counts, result register.
// Depends on mcbu_pkg.
module mcbu_datapath #(
	parameter int CORES    = 16,
	parameter int BARRIERS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mcbu_pkg::ctrl_cmd_t                 cmd,
	input  logic                                cfg_wr_en,
	input  logic [mcbu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcbu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_operation,
	input  logic [mcbu_pkg::CORE_W-1:0]         in_core,
	input  logic [mcbu_pkg::BAR_W-1:0]          in_barrier,
	input  logic                                in_immediate,
	output mcbu_pkg::status_t                   out_status,
	output logic [mcbu_pkg::BAR_W-1:0]          out_unlocked,
	output logic [mcbu_pkg::WAKE_W-1:0]         out_wake,
	output logic [mcbu_pkg::CNT_W-1:0]          out_pending
);

	localparam int CIW   = (CORES > 1) ? $clog2(CORES) : 1;
	localparam int BIW   = (BARRIERS > 1) ? $clog2(BARRIERS) : 1;
	localparam int ThrW  = mcbu_pkg::THR_W;
	localparam int BarW  = mcbu_pkg::BAR_W;
	localparam int WakeW = mcbu_pkg::WAKE_W;
	localparam int CntW  = mcbu_pkg::CNT_W;
	localparam int BiuW  = mcbu_pkg::BIU_W;

	logic [ThrW-1:0]  thr_q   [mcbu_pkg::NUM_THR];
	logic [BiuW-1:0]  biu_q;
	logic [ThrW-1:0]  cnt_q   [BARRIERS];
	logic [CORES-1:0] wait_q  [BARRIERS];
	logic [CORES-1:0] upd_q   [BARRIERS];
	logic [CntW-1:0]  pend_q  [CORES];

	logic [ThrW-1:0]  cnt_d   [BARRIERS];
	logic [CORES-1:0] wait_d  [BARRIERS];
	logic [CORES-1:0] upd_d   [BARRIERS];
	logic [CntW-1:0]  pend_d  [CORES];

	mcbu_pkg::status_t status_q;
	logic [BarW-1:0]   unl_q;
	logic [WakeW-1:0]  wake_q;
	logic [CntW-1:0]   pout_q;

	logic [CIW-1:0]    core_sel;
	logic [BIW-1:0]    bar_sel;
	logic              core_ok;
	logic              bar_ok;
	logic [ThrW-1:0]   cd;
	logic              opens;
	logic [CORES-1:0]  wake;
	logic [BARRIERS-1:0] hit;
	logic              found;
	logic [BIW-1:0]    first;
	logic [BiuW-1:0]   limit;
	mcbu_pkg::status_t status_d;
	logic [CntW-1:0]   pout_d;

	assign core_sel = CIW'(in_core);
	assign bar_sel  = BIW'(in_barrier);
	assign core_ok  = int'(in_core) < CORES;
	assign bar_ok   = int'(in_barrier) < BARRIERS;
	assign cd       = cnt_q[bar_sel];
	assign limit    = (int'(biu_q) < BARRIERS) ? biu_q : BiuW'(BARRIERS);

	// Lowest barrier in use that holds an update for the requesting core.
	// Only a check request looks for one.
	always_comb begin
		found = 1'b0;
		first = '0;
		for (int i = 0; i < BARRIERS; i++) begin
			hit[i] = (in_operation == mcbu_pkg::OP_CHECK) && core_ok &&
				(i < int'(limit)) && upd_q[i][core_sel];
		end
		for (int i = BARRIERS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found = 1'b1;
				first = BIW'(i);
			end
		end
	end

	always_comb begin
		for (int b = 0; b < BARRIERS; b++) begin
			cnt_d[b]  = cnt_q[b];
			wait_d[b] = wait_q[b];
			upd_d[b]  = upd_q[b];
		end
		opens    = 1'b0;
		wake     = '0;
		status_d = mcbu_pkg::STATUS_PENDING;
		if (in_operation == mcbu_pkg::OP_WAIT) begin
			if (bar_ok) begin
				if (cd > ThrW'(1)) begin
					if (!in_immediate && core_ok) begin
						cnt_d[bar_sel]            = cd - ThrW'(1);
						wait_d[bar_sel][core_sel] = 1'b1;
					end
				end else begin
					opens           = 1'b1;
					status_d        = mcbu_pkg::STATUS_GRANTED;
					wake            = wait_q[bar_sel];
					upd_d[bar_sel]  = upd_q[bar_sel] | wait_q[bar_sel];
					wait_d[bar_sel] = '0;
					cnt_d[bar_sel]  = thr_q[in_barrier];
				end
			end
		end else begin
			status_d = mcbu_pkg::STATUS_NONE;
			if (found) begin
				status_d              = mcbu_pkg::STATUS_FOUND;
				upd_d[first][core_sel] = 1'b0;
			end
		end
	end

	// Pending counts: saturating raise on an opening, floor-at-zero take on a check.
	always_comb begin
		for (int c = 0; c < CORES; c++) begin
			pend_d[c] = pend_q[c];
			if (opens && wake[c] && (pend_q[c] != mcbu_pkg::CNT_MAX)) begin
				pend_d[c] = pend_q[c] + CntW'(1);
			end
			if (found && (int'(core_sel) == c) && (pend_q[c] != '0)) begin
				pend_d[c] = pend_q[c] - CntW'(1);
			end
		end
		pout_d = core_ok ? pend_d[core_sel] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < mcbu_pkg::NUM_THR; t++) begin
				thr_q[t] <= mcbu_pkg::THR_RESET;
			end
			biu_q <= mcbu_pkg::BIU_RESET;
			for (int b = 0; b < BARRIERS; b++) begin
				cnt_q[b]  <= mcbu_pkg::THR_RESET;
				wait_q[b] <= '0;
				upd_q[b]  <= '0;
			end
			for (int c = 0; c < CORES; c++) begin
				pend_q[c] <= '0;
			end
		end else begin
			if (cmd.step_en) begin
				for (int b = 0; b < BARRIERS; b++) begin
					cnt_q[b]  <= cnt_d[b];
					wait_q[b] <= wait_d[b];
					upd_q[b]  <= upd_d[b];
				end
				for (int c = 0; c < CORES; c++) begin
					pend_q[c] <= pend_d[c];
				end
			end
			if (cfg_wr_en) begin
				if (cfg_index <= mcbu_pkg::REG_THRESHOLD_LAST) begin
					thr_q[cfg_index[1:0]] <= cfg_wdata[ThrW-1:0];
					if (int'(cfg_index) < BARRIERS) begin
						cnt_q[BIW'(cfg_index)]  <= cfg_wdata[ThrW-1:0];
						wait_q[BIW'(cfg_index)] <= '0;
						upd_q[BIW'(cfg_index)]  <= '0;
					end
				end else if (cfg_index == mcbu_pkg::REG_BARRIERS_IN_USE) begin
					biu_q <= cfg_wdata[BiuW-1:0];
				end
			end
		end
	end

	// Result register; loaded with every accepted request.
	always_ff @(posedge clk) begin
		if (cmd.step_en) begin
			status_q <= status_d;
			unl_q    <= found ? BarW'(first) : '0;
			wake_q   <= WakeW'(wake);
			pout_q   <= pout_d;
		end
	end

	assign out_status   = status_q;
	assign out_unlocked = unl_q;
	assign out_wake     = wake_q;
	assign out_pending  = pout_q;

endmodule

// ----- rtl/multi_core_barrier_unit_core.sv -----
// Barrier unit top level: controller, datapath, stream and config ports. Uses mcbu_pkg.
// A result is presented on the master side in the cycle after its request transfer.
// Throughput: one request per cycle while the master side keeps taking results; the
// datapath does the whole barrier update and the result register frees as it is taken.
// Reset: arst_n clears asynchronously all barriers, counts and configuration to defaults;
// no clearing pass is needed, requests are taken as soon as reset is released.
module multi_core_barrier_unit_core #(
	parameter int CORES    = 16,
	parameter int BARRIERS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Request stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [3:0] core_index, [5:4] barrier number, [6] immediate, [7] zero
	input  logic [mcbu_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [0] operation
	input  logic                                s_tuser,
	// Result stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] unlocked_barrier, [17:2] wake_mask, [20:18] pending_updates, [23:21] zero
	output logic [mcbu_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// [1:0] status
	output logic [1:0]                          m_tuser,
	// Configuration write port.
	input  logic                                cfg_wr_en,
	input  logic [mcbu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcbu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	mcbu_pkg::ctrl_cmd_t             cmd;
	mcbu_pkg::status_t               status;
	logic [mcbu_pkg::BAR_W-1:0]      unlocked;
	logic [mcbu_pkg::WAKE_W-1:0]     wake;
	logic [mcbu_pkg::CNT_W-1:0]      pending;

	// The controller only tracks whether the result register holds an
	// untaken result; every request transfer steps the datapath once.
	mcbu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// The datapath holds all barrier state and computes the full step in
	// the cycle of the transfer, including the count of the requesting core.
	mcbu_datapath #(
		.CORES    (CORES),
		.BARRIERS (BARRIERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_operation (s_tuser),
		.in_core      (s_tdata[3:0]),
		.in_barrier   (s_tdata[5:4]),
		.in_immediate (s_tdata[6]),
		.out_status   (status),
		.out_unlocked (unlocked),
		.out_wake     (wake),
		.out_pending  (pending)
	);

	// Pack the result fields, lowest field in the lowest bits.
	assign m_tdata = {3'b000, pending, wake, unlocked};
	assign m_tuser = status;

endmodule

// ----- rtl/mcbu_checker.sv -----
// Port-level checker for the barrier unit, bound to the top level.
// Depends on mcbu_pkg and multi_core_barrier_unit_core_defines.svh.
`include "multi_core_barrier_unit_core_defines.svh"

module mcbu_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [mcbu_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [1:0]                       m_tuser
);

	// A stalled result keeps its contents.
	`MCBU_ASSERT(a_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// Requests are taken whenever the result register is free or being drained.
	`MCBU_ASSERT(a_ready, clk, arst_n, s_tready == (!m_tvalid || m_tready), "request ready does not follow result register")

	// Every request transfer yields a result in the next cycle.
	`MCBU_ASSERT(a_result, clk, arst_n, s_tvalid && s_tready |=> m_tvalid, "request transfer without result")

	// Only an opening barrier wakes cores.
	`MCBU_ASSERT(a_wake, clk, arst_n, m_tvalid && (m_tuser != mcbu_pkg::STATUS_GRANTED) |-> m_tdata[17:2] == '0, "wake mask without opening")

	// No result is offered while reset is held.
	`MCBU_ASSERT_ALWAYS(a_rst, clk, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind multi_core_barrier_unit_core mcbu_checker u_mcbu_checker (.*);

// ----- bench/multi_core_barrier_unit_core_tb.sv -----
// Self-checking bench for the barrier unit: barrier rounds, update checks and threshold rewrites.
// Depends on mcbu_pkg and multi_core_barrier_unit_core with its controller and datapath.
module multi_core_barrier_unit_core_tb;
	import mcbu_pkg::*;

	localparam int NCORES = 16;
	localparam int NBAR   = 4;
	localparam int NPLANS = 8;
	localparam int ITEMS_PER_PLAN = 106;
	// Threshold registers of the first three barriers.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD2 = 3'd2;
	// Register indexes above the last real register are ignored by the block.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_BARRIERS_IN_USE + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

	// One request as the core side sees it.
	typedef struct packed {
		logic              op;
		logic [CORE_W-1:0] core;
		logic [BAR_W-1:0]  bar;
		logic              imm;
	} barrier_req_t;

	// One reply, split into the fields the result stream carries.
	typedef struct packed {
		status_t           status;
		logic [BAR_W-1:0]  bar;
		logic [WAKE_W-1:0] wake;
		logic [CNT_W-1:0]  pend;
	} barrier_reply_t;

	logic clk;
	logic arst_n = 1'b1;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = OP_WAIT;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Shadow copy of the barrier state and of the configuration registers.
	logic [THR_W-1:0]  thr_reg   [NBAR];
	logic [BIU_W-1:0]  scan_count;
	logic [THR_W-1:0]  countdown [NBAR];
	logic [WAKE_W-1:0] wait_mask [NBAR];
	logic [WAKE_W-1:0] upd_mask  [NBAR];
	logic [CNT_W-1:0]  pend_cnt  [NCORES];

	barrier_req_t   request_backlog[$];
	barrier_reply_t predicted_replies[$];
	barrier_req_t   bus_req;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int reply_count = 0;
	int grant_count = 0;
	int found_count = 0;
	int none_count = 0;
	int setting_count = 0;

	// Register settings swept by the random part. Zero, one and values above the
	// core count are all in the list, as are scan counts of zero and above four.
	logic [THR_W-1:0] plan_thr [NPLANS][NBAR] = '{
		'{5'd2,  5'd3,  5'd1,  5'd4},
		'{5'd16, 5'd2,  5'd0,  5'd3},
		'{5'd5,  5'd1,  5'd2,  5'd31},
		'{5'd3,  5'd3,  5'd3,  5'd3},
		'{5'd2,  5'd4,  5'd17, 5'd1},
		'{5'd0,  5'd2,  5'd5,  5'd16},
		'{5'd4,  5'd2,  5'd3,  5'd2},
		'{5'd1,  5'd31, 5'd2,  5'd6}
	};
	logic [BIU_W-1:0] plan_scan [NPLANS] = '{3'd4, 3'd7, 3'd2, 3'd0, 3'd1, 3'd3, 3'd4, 3'd5};

	multi_core_barrier_unit_core #(
		.CORES(NCORES),
		.BARRIERS(NBAR)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Applies one request to the shadow state and returns the reply it must produce.
	// A wait either opens its barrier (countdown at one or zero) or, unless immediate, counts down;
	// a check takes the lowest barrier, among those scanned, holding an update.
	function automatic barrier_reply_t apply_barrier_request(barrier_req_t r);
		barrier_reply_t rep;
		logic [WAKE_W-1:0] woken;
		int lim;
		int c;
		int b;
		rep.status = STATUS_PENDING;
		rep.bar = '0;
		rep.wake = '0;
		if (r.op == OP_WAIT) begin
			if (countdown[r.bar] > 5'd1) begin
				// An immediate request leaves the barrier untouched.
				if (!r.imm) begin
					countdown[r.bar] = countdown[r.bar] - 5'd1;
					wait_mask[r.bar][r.core] = 1'b1;
				end
			end else begin
				rep.status = STATUS_GRANTED;
				woken = wait_mask[r.bar];
				rep.wake = woken;
				for (c = 0; c < NCORES; c++) begin
					if (woken[c] && pend_cnt[c] != CNT_MAX)
						pend_cnt[c] = pend_cnt[c] + 3'd1;
				end
				upd_mask[r.bar] = upd_mask[r.bar] | woken;
				wait_mask[r.bar] = '0;
				countdown[r.bar] = thr_reg[r.bar];
			end
		end else begin
			rep.status = STATUS_NONE;
			lim = (scan_count < NBAR) ? int'(scan_count) : NBAR;
			for (b = 0; b < lim; b++) begin
				if (rep.status == STATUS_NONE && upd_mask[b][r.core]) begin
					upd_mask[b][r.core] = 1'b0;
					if (pend_cnt[r.core] != '0)
						pend_cnt[r.core] = pend_cnt[r.core] - 3'd1;
					rep.bar = b[BAR_W-1:0];
					rep.status = STATUS_FOUND;
				end
			end
		end
		rep.pend = pend_cnt[r.core];
		return rep;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Driver: the request on the bus is predicted once its transfer happens, and
	// when the slot is free a new one is picked from the backlog unless it idles at random.
	always @(posedge clk) begin : request_driver
		barrier_reply_t rep;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				rep = apply_barrier_request(bus_req);
				predicted_replies.push_back(rep);
			end
			if (!s_tvalid || s_tready) begin
				if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					bus_req = request_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {1'b0, bus_req.imm, bus_req.bar, bus_req.core};
					s_tuser <= bus_req.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stalls the result stream at random and compares every result
	// transfer, field by field, with the oldest prediction.
	always @(posedge clk) begin : reply_monitor
		barrier_reply_t want;
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_replies.size() == 0) begin
				report_mismatch($sformatf("result with nothing predicted (tdata %h)", m_tdata));
			end else begin
				want = predicted_replies.pop_front();
				reply_count++;
				if (want.status == STATUS_GRANTED) grant_count++;
				if (want.status == STATUS_FOUND) found_count++;
				if (want.status == STATUS_NONE) none_count++;
				if (m_tuser != want.status)
					report_mismatch($sformatf("status %0d, predicted %0d", m_tuser, want.status));
				if (m_tdata[1:0] != want.bar)
					report_mismatch($sformatf("barrier %0d, predicted %0d",
						m_tdata[1:0], want.bar));
				if (m_tdata[17:2] != want.wake)
					report_mismatch($sformatf("wake mask %h, predicted %h",
						m_tdata[17:2], want.wake));
				if (m_tdata[20:18] != want.pend)
					report_mismatch($sformatf("pending count %0d, predicted %0d",
						m_tdata[20:18], want.pend));
			end
		end
	end

	task automatic add_request(input logic op, input int core, input int bar, input logic imm);
		barrier_req_t r;
		r.op = op;
		r.core = core[CORE_W-1:0];
		r.bar = bar[BAR_W-1:0];
		r.imm = imm;
		request_backlog.push_back(r);
	endtask

	// Writes one register and mirrors it in the shadow copy. A threshold write
	// restarts its barrier; the per-core pending counts are left alone.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx <= REG_THRESHOLD_LAST) begin
			thr_reg[idx] = val;
			countdown[idx] = val;
			wait_mask[idx] = '0;
			upd_mask[idx] = '0;
		end else if (idx == REG_BARRIERS_IN_USE) begin
			scan_count = val[BIU_W-1:0];
		end
	endtask

	// Waits until every queued request has gone over and every reply has come
	// back, then lets the pipeline settle before anything is rewritten.
	task automatic settle();
		while (request_backlog.size() != 0 || s_tvalid || predicted_replies.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Random traffic: mostly complete barrier rounds (threshold minus one waits,
	// then the opening one) with checks sprinkled in, plus fully random requests.
	task automatic queue_random(input int n);
		int made;
		int b;
		int len;
		int k;
		logic imm;
		made = 0;
		while (made < n) begin
			if ($urandom_range(9) < 7) begin
				b = $urandom_range(NBAR - 1);
				len = (thr_reg[b] > 5'd1) ? int'(thr_reg[b]) : 1;
				for (k = 0; k < len; k++) begin
					if ($urandom_range(3) == 0) begin
						add_request(OP_CHECK, $urandom_range(NCORES - 1), $urandom_range(3),
							1'($urandom_range(1)));
						made++;
					end
					// Now and then an immediate request leaves the countdown alone, so the round may end without opening.
					imm = (k == len - 1) ? 1'($urandom_range(1)) : ($urandom_range(11) == 0);
					add_request(OP_WAIT, $urandom_range(NCORES - 1), b, imm);
					made++;
				end
			end else begin
				add_request(1'($urandom_range(1)), $urandom_range(NCORES - 1),
					$urandom_range(3), 1'($urandom_range(1)));
				made++;
			end
		end
	endtask

	initial begin : stimulus
		int p;
		int b;
		// Reset goes active just after time zero so that the block sees the edge.
		#1;
		arst_n = 1'b0;
		for (b = 0; b < NBAR; b++) begin
			thr_reg[b] = THR_RESET;
			countdown[b] = THR_RESET;
			wait_mask[b] = '0;
			upd_mask[b] = '0;
		end
		scan_count = BIU_RESET;
		for (b = 0; b < NCORES; b++) pend_cnt[b] = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 17;
		recv_idle_pct = 53;

		// Directed part, first under the reset settings: a check with nothing
		// taken and an immediate wait that must leave the barrier alone.
		add_request(OP_CHECK, 0, 0, 1'b0);
		add_request(OP_WAIT, 15, 3, 1'b1);
		settle();
		setting_count++;

		// Thresholds of two, one, zero and sixteen side by side.
		write_reg(REG_THRESHOLD0, 5'd2);
		write_reg(REG_THRESHOLD1, 5'd1);
		write_reg(REG_THRESHOLD2, 5'd0);
		write_reg(REG_THRESHOLD_LAST, 5'd16);
		write_reg(REG_BARRIERS_IN_USE, 5'd4);
		setting_count++;
		add_request(OP_WAIT, 15, 0, 1'b0);   // counts down, core 15 waits
		add_request(OP_WAIT, 0, 0, 1'b1);    // last arrival opens, wakes core 15
		add_request(OP_CHECK, 15, 0, 1'b0);  // takes that update
		add_request(OP_CHECK, 15, 0, 1'b0);  // nothing left, count already zero
		add_request(OP_WAIT, 7, 1, 1'b0);    // threshold one: every wait opens
		add_request(OP_WAIT, 0, 2, 1'b0);    // threshold zero: every wait opens
		add_request(OP_WAIT, 0, 3, 1'b1);
		add_request(OP_WAIT, 0, 3, 1'b0);
		add_request(OP_WAIT, 0, 3, 1'b0);    // repeated wait by a waiting core
		add_request(OP_WAIT, 0, 0, 1'b0);
		add_request(OP_WAIT, 15, 0, 1'b0);   // opens, wakes core 0
		add_request(OP_WAIT, 0, 0, 1'b0);
		add_request(OP_WAIT, 15, 0, 1'b1);   // opens again over the untaken update
		add_request(OP_CHECK, 0, 1, 1'b1);
		add_request(OP_CHECK, 0, 2, 1'b0);
		add_request(OP_WAIT, 5, 0, 1'b0);
		add_request(OP_WAIT, 3, 0, 1'b0);
		add_request(OP_CHECK, 5, 3, 1'b1);
		settle();

		for (p = 0; p < NPLANS; p++) begin
			if (p < 3) begin
				send_idle_pct = 17;
				recv_idle_pct = 53;
			end else if (p < 6) begin
				send_idle_pct = 53;
				recv_idle_pct = 17;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (b = 0; b < NBAR; b++)
				write_reg(b[CFG_IDX_W-1:0], plan_thr[p][b]);
			write_reg(REG_BARRIERS_IN_USE, {2'b00, plan_scan[p]});
			// Writes to the unused indexes must change nothing.
			if (p == 2) write_reg(REG_UNUSED_FIRST, 5'($urandom));
			if (p == 5) write_reg(REG_UNUSED_LAST, 5'd31);
			setting_count++;
			queue_random(ITEMS_PER_PLAN);
			settle();
		end

		repeat (10) @(posedge clk);
		$display("Run covered %0d replies under %0d register settings:", reply_count,
			setting_count);
		$display("  %0d barrier openings, %0d updates taken, %0d checks that found none.",
			grant_count, found_count, none_count);
		if (mismatch_count == 0 && predicted_replies.size() == 0) begin
			$display("multi_core_barrier_unit_core_tb passed");
		end else begin
			$display("multi_core_barrier_unit_core_tb failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, even with one side
	// stalling about half of the time.
	initial begin : watchdog
		#4000000;
		$display("Timeout: %0d replies still predicted", predicted_replies.size());
		$display("multi_core_barrier_unit_core_tb failed");
		$finish;
	end

endmodule
